### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the constrainer controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge outside reset.
`define OVC_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("ovc assertion failed");
// Same, with a caller-supplied message string.
`define OVC_ASSERT_MSG(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error(msg);
`else
`define OVC_ASSERT(lbl, clk_s, rst_s, prop)
`define OVC_ASSERT_MSG(lbl, clk_s, rst_s, prop, msg)
`endif

`endif

### design/ovc_pkg.sv
// ----------------------------------------------------------------------------
// ovc_pkg
// Shared constants, codes and control types of the option value constrainer.
// ----------------------------------------------------------------------------
package ovc_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int WORD_W         = 32;
  localparam int STEP_W         = 31;
  localparam int SLOT_W         = 4;
  localparam int COUNT_W        = 5;
  localparam int KIND_W         = 2;
  localparam int CFG_IDX_W      = 3;

  // Restoring divider: one numerator bit per beat of the iteration.
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_KIND      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTRAINT_KIND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_COUNT      = 3'd5;

  // Option types and constraint kinds.
  localparam logic [KIND_W-1:0] VK_BOOL     = 2'd0;
  localparam logic [KIND_W-1:0] VK_INT      = 2'd1;
  localparam logic [KIND_W-1:0] VK_STRING   = 2'd3;
  localparam logic [KIND_W-1:0] CK_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] CK_RANGE    = 2'd1;
  localparam logic [KIND_W-1:0] CK_LIST     = 2'd2;
  localparam logic [KIND_W-1:0] CK_STRLIST  = 2'd3;

  // Input commands.
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  // How one item is resolved.
  typedef enum logic [2:0] {
    RK_LOAD,
    RK_REJECT,
    RK_PASS,
    RK_CLAMP_LO,
    RK_CLAMP_HI,
    RK_STEP,
    RK_LIST
  } ovc_kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]  value_kind;
    logic [KIND_W-1:0]  constraint_kind;
    logic [WORD_W-1:0]  range_min;
    logic [WORD_W-1:0]  range_max;
    logic [STEP_W-1:0]  range_step;
    logic [COUNT_W-1:0] list_count;
  } ovc_cfg_t;

  typedef struct packed {
    logic capture;
    logic div_init;
    logic div_step;
    logic list_cmp;
    logic list_first;
    logic res_load;
  } ovc_cmd_t;

  typedef struct packed {
    ovc_kind_t kind;
  } ovc_stat_t;

endpackage

### design/ovc_ifs.sv
// ----------------------------------------------------------------------------
// ovc_ifs
// Valid/ready channels of the constrainer: input item and result item.
// ----------------------------------------------------------------------------
interface ovc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic signed [ovc_pkg::WORD_W-1:0] value;
  logic [ovc_pkg::SLOT_W-1:0]        entry_slot;

  modport source (output valid, cmd, value, entry_slot, input ready);
  modport sink   (input valid, cmd, value, entry_slot, output ready);
endinterface

interface ovc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ovc_pkg::WORD_W-1:0] snapped_value;
  logic                              inexact;
  logic                              accepted;
  logic                              exact;

  modport source (output valid, snapped_value, inexact, accepted, exact, input ready);
  modport sink   (input valid, snapped_value, inexact, accepted, exact, output ready);
endinterface

### design/ovc_ram.sv
// ----------------------------------------------------------------------------
// ovc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ovc_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/ovc_dp.sv
// ----------------------------------------------------------------------------
// ovc_dp
// Datapath: item capture, serial remainder unit, list walk and result register.
// ----------------------------------------------------------------------------
module ovc_dp #(
  parameter  int LIST_DEPTH = ovc_pkg::LIST_DEPTH_DEF,
  localparam int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                              clk,
  input  ovc_pkg::ovc_cfg_t                 cfg,
  input  ovc_pkg::ovc_cmd_t                 cmd,
  output ovc_pkg::ovc_stat_t                stat,
  input  logic [AW-1:0]                     rd_addr,
  input  logic                              in_cmd,
  input  logic signed [ovc_pkg::WORD_W-1:0] in_value,
  input  logic [ovc_pkg::SLOT_W-1:0]        in_entry_slot,
  output logic signed [ovc_pkg::WORD_W-1:0] res_value,
  output logic                              res_inexact,
  output logic                              res_accepted,
  output logic                              res_exact
);

  logic signed [31:0]  w_r;
  ovc_pkg::ovc_kind_t  kind_r, kind_nxt;
  logic [32:0]         num_r, num_nxt;
  logic [30:0]         rem_r, rem_nxt;
  logic [31:0]         best_r, best_nxt;
  logic [31:0]         bestd_r, bestd_nxt;
  logic signed [31:0]  res_value_r;
  logic                res_inexact_r, res_accepted_r, res_exact_r;

  logic                ram_we;
  logic [31:0]         ram_rdata;
  logic [29:0]         half;
  logic [32:0]         diff_min;
  logic [31:0]         rem_try;
  logic [32:0]         ldiff;
  logic [32:0]         lneg;
  logic [31:0]         ldist;
  logic signed [33:0]  rnd;
  logic                rnd_cap;

  logic signed [31:0]  v_nxt;
  logic                inx_nxt, acc_nxt, ex_nxt;

  // Word list table; a slot beyond the table depth is dropped.
  assign ram_we = cmd.capture && (in_cmd == ovc_pkg::CMD_LOAD) &&
                  (32'(in_entry_slot) < LIST_DEPTH);

  ovc_ram #(
    .WIDTH (ovc_pkg::WORD_W),
    .DEPTH (LIST_DEPTH)
  ) u_words (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_slot)),
    .wdata (in_value),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Classify the incoming item.
  always_comb begin
    kind_nxt = ovc_pkg::RK_PASS;
    if (in_cmd == ovc_pkg::CMD_LOAD) begin
      kind_nxt = ovc_pkg::RK_LOAD;
    end else if (cfg.value_kind == ovc_pkg::VK_STRING ||
                 cfg.constraint_kind == ovc_pkg::CK_STRLIST) begin
      kind_nxt = ovc_pkg::RK_REJECT;
    end else begin
      case (cfg.constraint_kind)
        ovc_pkg::CK_NONE: begin
          if (cfg.value_kind == ovc_pkg::VK_BOOL && in_value != 32'sd0 &&
              in_value != 32'sd1) begin
            kind_nxt = ovc_pkg::RK_REJECT;
          end else begin
            kind_nxt = ovc_pkg::RK_PASS;
          end
        end
        ovc_pkg::CK_RANGE: begin
          if (in_value < $signed(cfg.range_min)) begin
            kind_nxt = ovc_pkg::RK_CLAMP_LO;
          end else if (in_value > $signed(cfg.range_max)) begin
            kind_nxt = ovc_pkg::RK_CLAMP_HI;
          end else if (cfg.range_step != '0) begin
            kind_nxt = ovc_pkg::RK_STEP;
          end else begin
            kind_nxt = ovc_pkg::RK_PASS;
          end
        end
        ovc_pkg::CK_LIST: begin
          kind_nxt = ovc_pkg::RK_LIST;
        end
        default: begin
          kind_nxt = ovc_pkg::RK_REJECT;
        end
      endcase
    end
  end

  // Remainder of (value - min + step/2) by step, one bit per beat.
  assign half     = cfg.range_step[30:1];
  assign diff_min = {w_r[31], w_r} - {cfg.range_min[31], cfg.range_min};
  assign rem_try  = {rem_r, num_r[32]};

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    if (cmd.div_init) begin
      num_nxt = diff_min + {3'b000, half};
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      num_nxt = {num_r[31:0], 1'b0};
      if (rem_try >= {1'b0, cfg.range_step}) begin
        rem_nxt = 31'(rem_try - {1'b0, cfg.range_step});
      end else begin
        rem_nxt = rem_try[30:0];
      end
    end
  end

  // Nearest list entry; a strictly smaller distance replaces the best.
  assign ldiff = {w_r[31], w_r} - {ram_rdata[31], ram_rdata};
  assign lneg  = -ldiff;
  assign ldist = ldiff[32] ? lneg[31:0] : ldiff[31:0];

  always_comb begin
    best_nxt  = best_r;
    bestd_nxt = bestd_r;
    if (cmd.list_cmp && (cmd.list_first || ldist < bestd_r)) begin
      best_nxt  = ram_rdata;
      bestd_nxt = ldist;
    end
  end

  // Rounded value is value + step/2 - remainder; cap it at the maximum.
  assign rnd     = {{2{w_r[31]}}, w_r} + {4'b0000, half} - {3'b000, rem_r};
  assign rnd_cap = rnd > $signed({{2{cfg.range_max[31]}}, cfg.range_max});

  always_comb begin
    v_nxt   = w_r;
    inx_nxt = 1'b0;
    acc_nxt = 1'b1;
    ex_nxt  = 1'b0;
    case (kind_r)
      ovc_pkg::RK_LOAD: begin
        v_nxt = w_r;
      end
      ovc_pkg::RK_REJECT: begin
        acc_nxt = 1'b0;
      end
      ovc_pkg::RK_PASS: begin
        ex_nxt = 1'b1;
      end
      ovc_pkg::RK_CLAMP_LO: begin
        v_nxt   = $signed(cfg.range_min);
        inx_nxt = 1'b1;
      end
      ovc_pkg::RK_CLAMP_HI: begin
        v_nxt   = $signed(cfg.range_max);
        inx_nxt = 1'b1;
      end
      ovc_pkg::RK_STEP: begin
        v_nxt   = rnd_cap ? $signed(cfg.range_max) : rnd[31:0];
        inx_nxt = (v_nxt != w_r);
        ex_nxt  = ({1'b0, half} == rem_r);
      end
      ovc_pkg::RK_LIST: begin
        v_nxt   = $signed(best_r);
        inx_nxt = (best_r != w_r);
        ex_nxt  = (best_r == w_r);
      end
      default: begin
        acc_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w_r    <= in_value;
      kind_r <= kind_nxt;
    end
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    best_r  <= best_nxt;
    bestd_r <= bestd_nxt;
    if (cmd.res_load) begin
      res_value_r    <= v_nxt;
      res_inexact_r  <= inx_nxt;
      res_accepted_r <= acc_nxt;
      res_exact_r    <= ex_nxt;
    end
  end

  assign stat.kind    = kind_r;
  assign res_value    = res_value_r;
  assign res_inexact  = res_inexact_r;
  assign res_accepted = res_accepted_r;
  assign res_exact    = res_exact_r;

endmodule

### design/ovc_ctrl.sv
// ----------------------------------------------------------------------------
// ovc_ctrl
// Controller: sequences capture, division, list walk and result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ovc_ctrl #(
  parameter  int LIST_DEPTH = ovc_pkg::LIST_DEPTH_DEF,
  localparam int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int CW         = $clog2(LIST_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  logic [ovc_pkg::COUNT_W-1:0]  list_count,
  input  ovc_pkg::ovc_stat_t           stat,
  output ovc_pkg::ovc_cmd_t            cmd,
  output logic [AW-1:0]                rd_addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_LREQ,
    S_LCMP,
    S_FIN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [ovc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [CW-1:0]               n_ent;

  // Saturate the entry count to 1..LIST_DEPTH.
  always_comb begin
    if (list_count == '0) begin
      n_ent = CW'(1);
    end else if (32'(list_count) > LIST_DEPTH) begin
      n_ent = CW'(LIST_DEPTH);
    end else begin
      n_ent = CW'(list_count);
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          ovc_pkg::RK_STEP: begin
            cmd.div_init = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_DIV;
          end
          ovc_pkg::RK_LIST: begin
            idx_nxt   = '0;
            state_nxt = S_LREQ;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == ovc_pkg::DIV_CNT_W'(ovc_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LREQ: begin
        state_nxt = S_LCMP;
      end
      S_LCMP: begin
        cmd.list_cmp   = 1'b1;
        cmd.list_first = (idx_r == '0);
        if (({1'b0, idx_r} + 1'b1) == {1'b0, n_ent}) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LREQ;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign rd_addr   = idx_r[AW-1:0];

  `OVC_ASSERT(a_load_free, clk, rst_n, cmd.res_load |-> (!out_valid_r || out_ready))
  `OVC_ASSERT(a_accept_decode, clk, rst_n, (in_valid && in_ready) |=> state_r == S_DECODE)
  `OVC_ASSERT_MSG(a_div_bound, clk, rst_n, state_r == S_DIV |-> cnt_r < ovc_pkg::DIV_STEPS, "divider count overrun")
  `OVC_ASSERT_MSG(a_idx_bound, clk, rst_n, state_r == S_LCMP |-> idx_r < n_ent, "list index past entry count")
  `OVC_ASSERT(a_load_valid, clk, rst_n, cmd.res_load |=> out_valid)

endmodule

### design/option_value_constrainer.sv
// ----------------------------------------------------------------------------
// option_value_constrainer
// Snaps an option value to its range or word-list constraint.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch (valid/ready). A beat with cmd load writes
// value into word-list slot entry_slot; a check beat constrains value by the
// configuration registers. Every item yields exactly one result beat on
// out_ch: snapped_value with inexact, accepted and exact flags.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle, the block itself does not enforce it.
// Path to out_ch.valid: load, reject, pass and clamp go from capture and
// decode to the result register; range with a step runs the restoring
// remainder loop first; word list does one RAM read and one compare per
// entry, N entries, N the saturated list count.
// One item is in work at a time; in_ch.ready rises on the same edge that
// loads the result into the output register. The output register holds a
// result while the receiver stalls; the next item may be accepted
// meanwhile, and its result waits in the controller until the register
// frees up.
// Reset (rst_n low, synchronous) clears control and sets the configuration
// registers to defaults; the word list is undefined until loaded.
// ----------------------------------------------------------------------------
module option_value_constrainer #(
  parameter  int LIST_DEPTH = ovc_pkg::LIST_DEPTH_DEF,
  localparam int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ovc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ovc_pkg::WORD_W-1:0]        cfg_wdata,
  ovc_in_if.sink                            in_ch,
  ovc_out_if.source                         out_ch
);

  ovc_pkg::ovc_cfg_t  cfg_r;
  ovc_pkg::ovc_cmd_t  cmd;
  ovc_pkg::ovc_stat_t stat;
  logic [AW-1:0]      rd_addr;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.value_kind      <= ovc_pkg::VK_INT;
      cfg_r.constraint_kind <= ovc_pkg::CK_NONE;
      cfg_r.range_min       <= '0;
      cfg_r.range_max       <= '0;
      cfg_r.range_step      <= '0;
      cfg_r.list_count      <= ovc_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ovc_pkg::CFG_VALUE_KIND:      cfg_r.value_kind      <= cfg_wdata[ovc_pkg::KIND_W-1:0];
        ovc_pkg::CFG_CONSTRAINT_KIND: cfg_r.constraint_kind <= cfg_wdata[ovc_pkg::KIND_W-1:0];
        ovc_pkg::CFG_RANGE_MIN:       cfg_r.range_min       <= cfg_wdata;
        ovc_pkg::CFG_RANGE_MAX:       cfg_r.range_max       <= cfg_wdata;
        ovc_pkg::CFG_RANGE_STEP:      cfg_r.range_step      <= cfg_wdata[ovc_pkg::STEP_W-1:0];
        ovc_pkg::CFG_LIST_COUNT:      cfg_r.list_count      <= cfg_wdata[ovc_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequence the item: capture, decode, divide or walk the list, hand off.
  ovc_ctrl #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .list_count (cfg_r.list_count),
    .stat       (stat),
    .cmd        (cmd),
    .rd_addr    (rd_addr)
  );

  // Hold the item, the remainder unit, the list best and the result beat.
  ovc_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk           (clk),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .stat          (stat),
    .rd_addr       (rd_addr),
    .in_cmd        (in_ch.cmd),
    .in_value      (in_ch.value),
    .in_entry_slot (in_ch.entry_slot),
    .res_value     (out_ch.snapped_value),
    .res_inexact   (out_ch.inexact),
    .res_accepted  (out_ch.accepted),
    .res_exact     (out_ch.exact)
  );

endmodule
